/* design/packed_bit_array_access_defines.svh */
// Assertion macros for the packed bit array access block.
// Included by the top level; no other dependencies.
`ifndef PACKED_BIT_ARRAY_ACCESS_DEFINES_SVH
`define PACKED_BIT_ARRAY_ACCESS_DEFINES_SVH

// same-cycle implication under active-low reset
`define PBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pba assertion failed");

// next-cycle implication under active-low reset
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pba assertion failed");

`endif

/* design/pba_pkg.sv */
// Shared types and constants for the packed bit array access block.
// No dependencies.
package pba_pkg;

    localparam int WORD_BITS = 32;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_WIDE  = 2'd2;

    localparam logic [7:0] REG_ELEMENT_COUNT = 8'd0;
    localparam logic [7:0] REG_FIELD_WIDTH   = 8'd1;

    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_CHECK = 11'b00000000100,
        ST_RD1   = 11'b00000001000,
        ST_RD2   = 11'b00000010000,
        ST_EXT   = 11'b00000100000,
        ST_MSK   = 11'b00001000000,
        ST_INS   = 11'b00010000000,
        ST_WR1   = 11'b00100000000,
        ST_WR2   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

endpackage

/* design/packed_bit_array_access.sv */
// Packed bit array access: word store, offset multiply, shared window shifter, sequencer.
// Depends on pba_pkg and packed_bit_array_access_defines.svh.
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: index, value; tuser: mode
// m_axis    out  m_axis_tvalid/tready       tdata: read value; tuser: status
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Each access runs to completion before the next is taken: check, reads, then extract, or
// for a write mask, insert and write-back; a rejected access goes straight to the output.
// All steps share the single memory port and the one 64-bit window shifter that serves
// extract, mask and insert. After reset a clearing pass zeroes every word of the store
// with s_axis_tready low; cfg writes are taken at all times.
// A result waits in the output register; the block holds in its final step until it leaves.
`include "packed_bit_array_access_defines.svh"

module packed_bit_array_access #(
    parameter int STORE_WORDS = 2048,
    parameter int INDEX_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // element_index, write_value, zero fill
    input  logic [((INDEX_BITS+32+7)/8)*8-1:0]     s_axis_tdata,
    // mode
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // read_value
    output logic [31:0]                            m_axis_tdata,
    // status
    output logic [1:0]                             m_axis_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [7:0]                             cfg_index,
    input  logic [31:0]                            cfg_data
);
    import pba_pkg::*;

    localparam int AW         = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CMP_W      = ((INDEX_BITS > AW) ? INDEX_BITS : AW) + 6;
    localparam logic [CMP_W-1:0] TOTAL_BITS = CMP_W'(STORE_WORDS * WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [16:0]            count_reg, count_next;
    logic [5:0]             fw_reg, fw_next;

    logic                   mode_reg;
    logic [INDEX_BITS-1:0]  idx_reg;
    logic [31:0]            val_reg;
    logic [CMP_W-1:0]       off_reg;
    logic [AW-1:0]          first_reg;
    logic                   has_second_reg;
    logic [5:0]             shift_reg;
    logic [31:0]            hi_reg;
    logic [63:0]            win_reg;
    logic [31:0]            res_value_reg;
    logic [1:0]             res_status_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg;
    logic [1:0]             out_status_reg;

    logic [31:0]            mem [STORE_WORDS];
    logic [31:0]            rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [31:0]            mem_wdata;

    logic [5:0]             eff_w;
    logic [31:0]            val_mask;
    logic [CMP_W-1:0]       end_bit;
    logic                   range_err;
    logic                   wide_err;
    logic [AW-1:0]          first_w;
    logic [6:0]             shift_w;
    logic                   s_accept;
    logic                   out_free;

    logic                   sh_left;
    logic [63:0]            sh_op;
    logic [63:0]            sh_out;

    assign eff_w    = (fw_reg == 6'd0) ? 6'd1 : ((fw_reg > 6'd32) ? 6'd32 : fw_reg);
    assign val_mask = (eff_w == 6'd32) ? 32'hffff_ffff : ((32'd1 << eff_w) - 32'd1);

    assign end_bit   = off_reg + CMP_W'(eff_w);
    assign range_err = (CMP_W'(idx_reg) >= CMP_W'(count_reg)) || (end_bit > TOTAL_BITS);
    assign wide_err  = (mode_reg == MODE_WRITE) && (val_reg > val_mask);
    assign first_w   = off_reg[AW+4:5];
    assign shift_w   = 7'd64 - {2'b00, off_reg[4:0]} - {1'b0, eff_w};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        sh_left = 1'b1;
        sh_op   = {32'd0, val_mask};
        case (state_reg)
            ST_EXT:
            begin
                sh_left = 1'b0;
                sh_op   = win_reg;
            end
            ST_INS:
            begin
                sh_op = {32'd0, val_reg};
            end
            default:
            begin
                sh_op = {32'd0, val_mask};
            end
        endcase
        sh_out = sh_left ? (sh_op << shift_reg) : (sh_op >> shift_reg);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = first_reg;
        mem_wdata = 32'd0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            ST_CHECK:
            begin
                mem_addr = first_w;
            end
            ST_RD1:
            begin
                mem_addr = has_second_reg ? first_reg + AW'(1) : first_reg;
            end
            ST_WR1:
            begin
                mem_we    = 1'b1;
                mem_wdata = win_reg[63:32];
            end
            ST_WR2:
            begin
                mem_we    = 1'b1;
                mem_addr  = first_reg + AW'(1);
                mem_wdata = win_reg[31:0];
            end
            default:
            begin
                mem_addr = first_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        fw_next        = fw_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ELEMENT_COUNT: count_next = cfg_data[16:0];
                REG_FIELD_WIDTH:   fw_next    = cfg_data[5:0];
                default:           count_next = count_reg;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (range_err || wide_err) ? ST_OUT : ST_RD1;
            end
            ST_RD1:
            begin
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                state_next = (mode_reg == MODE_WRITE) ? ST_MSK : ST_EXT;
            end
            ST_EXT:
            begin
                state_next = ST_OUT;
            end
            ST_MSK:
            begin
                state_next = ST_INS;
            end
            ST_INS:
            begin
                state_next = ST_WR1;
            end
            ST_WR1:
            begin
                state_next = has_second_reg ? ST_WR2 : ST_OUT;
            end
            ST_WR2:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= 17'd0;
            fw_reg        <= 6'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            fw_reg        <= fw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mode_reg <= s_axis_tuser;
            idx_reg  <= s_axis_tdata[INDEX_BITS-1:0];
            val_reg  <= s_axis_tdata[INDEX_BITS+31:INDEX_BITS];
            off_reg  <= CMP_W'(CMP_W'(s_axis_tdata[INDEX_BITS-1:0]) * CMP_W'(eff_w));
        end
        case (state_reg)
            ST_CHECK:
            begin
                first_reg      <= first_w;
                has_second_reg <= (first_w != LAST_WORD);
                shift_reg      <= shift_w[5:0];
                res_value_reg  <= 32'd0;
                res_status_reg <= range_err ? STATUS_RANGE
                                : (wide_err ? STATUS_WIDE : STATUS_OK);
            end
            ST_RD1:
            begin
                hi_reg <= rd_data_reg;
            end
            ST_RD2:
            begin
                win_reg <= {hi_reg, has_second_reg ? rd_data_reg : 32'd0};
            end
            ST_EXT:
            begin
                res_value_reg <= sh_out[31:0] & val_mask;
            end
            ST_MSK:
            begin
                win_reg <= win_reg & ~sh_out;
            end
            ST_INS:
            begin
                win_reg <= win_reg | sh_out;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg   <= res_value_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default:
            begin
                hi_reg <= hi_reg;
            end
        endcase
    end

    `PBA_ASSERT_NEXT(a_accept_to_check, clk, rst_n, s_accept, state_reg == ST_CHECK)
    `PBA_ASSERT_NOW(a_fail_reads_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata == 32'd0)
    `PBA_ASSERT_NOW(a_wr2_after_wr1, clk, rst_n, state_reg == ST_WR2,
        $past(state_reg) == ST_WR1 && has_second_reg)

endmodule
